@@ rtl/bmsm_pkg.sv @@
// Shared types, action codes and reset tables for the banked memory slot mapper.
package bmsm_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int SLOT_W    = 3;
    localparam int PAGE_W    = 8;
    localparam int BANK_W    = 7;

    localparam logic [PAGE_W-1:0] VIEW_ROM   = 8'hFF;
    localparam logic [4:0]        EXT_MASK   = 5'h1F;
    localparam logic [1:0]        MODE_1024  = 2'd3;

    typedef enum logic [3:0] {
        ACT_BANK_PORT  = 4'd0,
        ACT_PLUS3_PORT = 4'd1,
        ACT_EXT_PORT   = 4'd2,
        ACT_EFF7_PORT  = 4'd3,
        ACT_MODE_REG   = 4'd4,
        ACT_SET_RAM    = 4'd5,
        ACT_MAP_ROM    = 4'd6,
        ACT_READ       = 4'd7,
        ACT_SOFT_RESET = 4'd8,
        ACT_HARD_RESET = 4'd9
    } action_t;

    typedef struct packed {
        logic [PAGE_W-1:0] slot_page;
        logic              slot_is_rom;
        logic [PAGE_W-1:0] register_view;
        logic              lock_active;
        logic              write_ignored;
    } result_t;

    function automatic logic [PAGE_W-1:0] reset_page(input logic [SLOT_W-1:0] s);
        logic [PAGE_W-1:0] p;
        case (s)
            3'd0:    p = 8'h00;
            3'd1:    p = 8'h01;
            3'd2:    p = 8'h0A;
            3'd3:    p = 8'h0B;
            3'd4:    p = 8'h04;
            3'd5:    p = 8'h05;
            3'd6:    p = 8'h00;
            default: p = 8'h01;
        endcase
        return p;
    endfunction

    function automatic logic [PAGE_W-1:0] reset_view(input logic [SLOT_W-1:0] s);
        logic [PAGE_W-1:0] p;
        if (s < 3'd2)
            p = VIEW_ROM;
        else
            p = reset_page(s);
        return p;
    endfunction

    // Bank of the given 16 KB segment in a +3 all-RAM layout.
    function automatic logic [2:0] special_bank(input logic [1:0] cfg, input logic [1:0] seg);
        logic [2:0] b;
        case ({cfg, seg})
            4'b00_00: b = 3'd0;
            4'b00_01: b = 3'd1;
            4'b00_10: b = 3'd2;
            4'b00_11: b = 3'd3;
            4'b01_00: b = 3'd4;
            4'b01_01: b = 3'd5;
            4'b01_10: b = 3'd6;
            4'b01_11: b = 3'd7;
            4'b10_00: b = 3'd4;
            4'b10_01: b = 3'd5;
            4'b10_10: b = 3'd6;
            4'b10_11: b = 3'd3;
            4'b11_00: b = 3'd4;
            4'b11_01: b = 3'd7;
            4'b11_10: b = 3'd6;
            default:  b = 3'd3;
        endcase
        return b;
    endfunction

endpackage

@@ rtl/banked_memory_slot_mapper.sv @@
// Top level of the banked memory slot mapper: input register, slot table, result register.
//
// The block keeps eight 8 KB slot mappings and applies one paging action per
// item: port writes, direct RAM or ROM slot writes, reads and soft or hard
// resets. Every item produces exactly one result, reported for the slot
// given in the item and sampled after the item has taken effect. Items are
// taken one per clock cycle while the result side is not stalled; each item
// is held in the input register, and the result register is loaded when the
// core takes it. The whole state update for an item is combinational logic
// between those two registers, so consecutive items see each other's effects
// with no bubbles. A stalled result holds the pipeline; the input register
// still takes one more item while the result waits. The mapping mode
// register is cleared only by rst_n, never by the reset actions.
module banked_memory_slot_mapper (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // action[3:0], slot[6:4], value[14:7], zero[15]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // slot_page[7:0], slot_is_rom[8], register_view[16:9],
                                   // lock_active[17], write_ignored[18], zero[23:19]
);
    import bmsm_pkg::*;

    logic              in_valid_reg;
    action_t           in_action_reg;
    logic [2:0]        in_slot_reg;
    logic [7:0]        in_value_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_result_reg;
    result_t           core_result;
    logic              advance;
    logic              fire;

    // Advance when the result register is empty or being drained.
    assign advance  = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    bmsm_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (fire),
        .action (in_action_reg),
        .slot   (in_slot_reg),
        .value  (in_value_reg),
        .result (core_result)
    );

    // Hold the item in the input register until the core takes it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_action_reg <= action_t'(s_tdata[3:0]);
            in_slot_reg   <= s_tdata[6:4];
            in_value_reg  <= s_tdata[14:7];
        end
        if (fire)
            out_result_reg <= core_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0,
                       out_result_reg.write_ignored,
                       out_result_reg.lock_active,
                       out_result_reg.register_view,
                       out_result_reg.slot_is_rom,
                       out_result_reg.slot_page};

endmodule

@@ rtl/bmsm_core.sv @@
// Slot table and paging registers with the update logic for one item.
module bmsm_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  bmsm_pkg::action_t      action,
    input  logic [2:0]             slot,
    input  logic [7:0]             value,
    output bmsm_pkg::result_t      result
);
    import bmsm_pkg::*;

    logic [PAGE_W-1:0] pages_reg [NUM_SLOTS];
    logic [PAGE_W-1:0] pages_next [NUM_SLOTS];
    logic              rom_reg [NUM_SLOTS];
    logic              rom_next [NUM_SLOTS];
    logic [PAGE_W-1:0] views_reg [NUM_SLOTS];
    logic [PAGE_W-1:0] views_next [NUM_SLOTS];
    logic [7:0]        bank_reg, bank_next;
    logic [7:0]        plus3_reg, plus3_next;
    logic [4:0]        ext_reg, ext_next;
    logic [1:0]        raz_reg, raz_next;
    logic [1:0]        mode_reg, mode_next;
    logic              lock_reg, lock_next;

    logic              lock_eff_cur;
    logic              lock_eff_new;
    logic              ignored;
    logic              do_recompose;
    logic              do_rom_pair;
    logic              m1024_new;
    logic [BANK_W-1:0] bank_num;
    logic [PAGE_W-1:0] rom_base;
    logic [1:0]        cfg;
    logic [2:0]        sb;

    assign lock_eff_cur = lock_reg && !(mode_reg == MODE_1024 && !raz_reg[0]);

    always_comb
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            pages_next[i] = pages_reg[i];
            rom_next[i]   = rom_reg[i];
            views_next[i] = views_reg[i];
        end
        bank_next    = bank_reg;
        plus3_next   = plus3_reg;
        ext_next     = ext_reg;
        raz_next     = raz_reg;
        mode_next    = mode_reg;
        lock_next    = lock_reg;
        ignored      = 1'b0;
        do_recompose = 1'b0;
        do_rom_pair  = 1'b0;
        cfg          = value[2:1];
        sb           = 3'd0;

        unique case (action)
            ACT_BANK_PORT:
            begin
                if (lock_eff_cur)
                    ignored = 1'b1;
                else
                begin
                    lock_next    = value[5];
                    bank_next    = value;
                    do_recompose = 1'b1;
                end
            end
            ACT_PLUS3_PORT:
            begin
                if (lock_eff_cur)
                    ignored = 1'b1;
                else
                begin
                    plus3_next = value;
                    if (value[0])
                    begin
                        for (int seg = 0; seg < 4; seg++)
                        begin
                            sb = special_bank(cfg, 2'(seg));
                            pages_next[2*seg]   = {4'd0, sb, 1'b0};
                            pages_next[2*seg+1] = {4'd0, sb, 1'b1};
                            views_next[2*seg]   = {4'd0, sb, 1'b0};
                            views_next[2*seg+1] = {4'd0, sb, 1'b1};
                            rom_next[2*seg]     = 1'b0;
                            rom_next[2*seg+1]   = 1'b0;
                        end
                    end
                    else
                        do_rom_pair = 1'b1;
                end
            end
            ACT_EXT_PORT:
            begin
                if (lock_eff_cur)
                    ignored = 1'b1;
                else
                begin
                    ext_next     = value[4:0] & EXT_MASK;
                    do_recompose = 1'b1;
                end
            end
            ACT_EFF7_PORT:
            begin
                raz_next     = {value[3], value[2]};
                do_recompose = 1'b1;
            end
            ACT_MODE_REG:
            begin
                mode_next    = value[1:0];
                do_recompose = 1'b1;
            end
            ACT_SET_RAM:
            begin
                pages_next[slot] = value;
                rom_next[slot]   = 1'b0;
                views_next[slot] = value;
            end
            ACT_MAP_ROM:
            begin
                pages_next[slot] = value;
                rom_next[slot]   = 1'b1;
                views_next[slot] = VIEW_ROM;
            end
            ACT_SOFT_RESET, ACT_HARD_RESET:
            begin
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    pages_next[i] = reset_page(3'(i));
                    views_next[i] = reset_view(3'(i));
                    rom_next[i]   = (i < 2);
                end
                if (action == ACT_HARD_RESET)
                begin
                    bank_next  = 8'd0;
                    plus3_next = 8'd0;
                    ext_next   = 5'd0;
                    raz_next   = 2'd0;
                    lock_next  = 1'b0;
                end
                else
                    do_recompose = 1'b1;
            end
            default:
            begin
            end
        endcase

        // Recompose from the updated port registers.
        m1024_new = (mode_next == MODE_1024) && !raz_next[0];
        if (mode_next[1])
            bank_num = {1'b0, m1024_new & bank_next[5], bank_next[7:6], bank_next[2:0]};
        else
            bank_num = {ext_next[3:0], bank_next[2:0]};
        rom_base = {5'd0, plus3_next[2], bank_next[4], 1'b0};

        if (do_recompose)
        begin
            pages_next[6] = {bank_num, 1'b0};
            pages_next[7] = {bank_num, 1'b1};
            views_next[6] = {bank_num, 1'b0};
            views_next[7] = {bank_num, 1'b1};
            rom_next[6]   = 1'b0;
            rom_next[7]   = 1'b0;
            if (raz_next[1])
            begin
                pages_next[0] = 8'h00;
                pages_next[1] = 8'h01;
                views_next[0] = 8'h00;
                views_next[1] = 8'h01;
                rom_next[0]   = 1'b0;
                rom_next[1]   = 1'b0;
            end
        end
        if (do_rom_pair || (do_recompose && !raz_next[1]))
        begin
            pages_next[0] = rom_base;
            pages_next[1] = rom_base | 8'h01;
            views_next[0] = rom_base;
            views_next[1] = rom_base | 8'h01;
            rom_next[0]   = 1'b1;
            rom_next[1]   = 1'b1;
        end

        lock_eff_new = lock_next && !m1024_new;

        result.slot_page     = pages_next[slot];
        result.slot_is_rom   = rom_next[slot];
        result.register_view = views_next[slot];
        result.lock_active   = lock_eff_new;
        result.write_ignored = ignored;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                pages_reg[i] <= reset_page(3'(i));
                views_reg[i] <= reset_view(3'(i));
                rom_reg[i]   <= (i < 2);
            end
            bank_reg  <= 8'd0;
            plus3_reg <= 8'd0;
            ext_reg   <= 5'd0;
            raz_reg   <= 2'd0;
            mode_reg  <= 2'd0;
            lock_reg  <= 1'b0;
        end
        else if (en)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
            begin
                pages_reg[i] <= pages_next[i];
                views_reg[i] <= views_next[i];
                rom_reg[i]   <= rom_next[i];
            end
            bank_reg  <= bank_next;
            plus3_reg <= plus3_next;
            ext_reg   <= ext_next;
            raz_reg   <= raz_next;
            mode_reg  <= mode_next;
            lock_reg  <= lock_next;
        end
    end

endmodule

@@ sim/bmsm_checker.sv @@
// Scoreboard for the slot mapper: mirrors the paging state and checks each result.
module bmsm_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,     // action[3:0], slot[6:4], value[14:7], zero[15]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,     // slot_page[7:0], slot_is_rom[8], register_view[16:9],
                                     // lock_active[17], write_ignored[18], zero[23:19]
    output int          errors,
    output int          outstanding
);
    import bmsm_pkg::*;

    // Pages after reset, slot 0 in the lowest byte.
    localparam logic [7:0][7:0] HOME_PAGES =
        {8'h01, 8'h00, 8'h05, 8'h04, 8'h0B, 8'h0A, 8'h01, 8'h00};
    // Banks of the +3 all-RAM layouts, entry {cfg, seg}, entry 0 lowest.
    localparam logic [15:0][2:0] ALLRAM_BANKS =
        {3'd3, 3'd6, 3'd7, 3'd4, 3'd3, 3'd6, 3'd5, 3'd4,
         3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0};

    logic [7:0] pages [NUM_SLOTS];
    logic       rom_flags [NUM_SLOTS];
    logic [7:0] views [NUM_SLOTS];
    logic [7:0] bank_port;
    logic [7:0] plus3_port;
    logic [4:0] ext_bank;
    logic [1:0] ram_at_zero;
    logic [1:0] map_mode;
    logic       lock_bit;

    result_t    pending_results [$];
    int         mismatch_cnt;

    function automatic logic in_1024_mode();
        return map_mode == MODE_1024 && !ram_at_zero[0];
    endfunction

    function automatic logic lock_held();
        return lock_bit && !in_1024_mode();
    endfunction

    function automatic void map_ram(input int s, input logic [7:0] page);
        pages[s]     = page;
        rom_flags[s] = 1'b0;
        views[s]     = page;
    endfunction

    function automatic void map_rom_pair();
        logic [7:0] p;
        p = {5'd0, plus3_port[2], bank_port[4], 1'b0};
        pages[0]     = p;
        pages[1]     = p | 8'h01;
        rom_flags[0] = 1'b1;
        rom_flags[1] = 1'b1;
        views[0]     = p;
        views[1]     = p | 8'h01;
    endfunction

    function automatic void load_home_table();
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            pages[i]     = HOME_PAGES[i];
            rom_flags[i] = (i < 2);
            views[i]     = (i < 2) ? VIEW_ROM : HOME_PAGES[i];
        end
    endfunction

    // Rebuild the upper bank in slots 6/7 and the low pair from the port registers.
    function automatic void rebuild_mapping();
        logic [BANK_W-1:0] bank;
        bank = {4'd0, bank_port[2:0]};
        if (map_mode[1])
        begin
            bank[4:3] = bank_port[7:6];
            if (in_1024_mode())
                bank[5] = bank_port[5];
        end
        else
        begin
            bank[6:3] = ext_bank[3:0];
        end
        map_ram(6, {bank, 1'b0});
        map_ram(7, {bank, 1'b1});
        if (ram_at_zero[1])
        begin
            map_ram(0, 8'h00);
            map_ram(1, 8'h01);
        end
        else
        begin
            map_rom_pair();
        end
    endfunction

    // Apply one item to the mirrored state and return what the block must report.
    function automatic result_t apply_paging(input logic [3:0] code, input logic [2:0] s,
                                             input logic [7:0] v);
        result_t r;
        logic    dropped;
        dropped = 1'b0;
        case (code)
            ACT_BANK_PORT:
            begin
                if (lock_held())
                begin
                    dropped = 1'b1;
                end
                else
                begin
                    lock_bit  = v[5];
                    bank_port = v;
                    rebuild_mapping();
                end
            end
            ACT_PLUS3_PORT:
            begin
                if (lock_held())
                begin
                    dropped = 1'b1;
                end
                else
                begin
                    plus3_port = v;
                    if (v[0])
                    begin
                        for (int seg = 0; seg < 4; seg++)
                        begin
                            map_ram(seg * 2,     {4'd0, ALLRAM_BANKS[v[2:1] * 4 + seg], 1'b0});
                            map_ram(seg * 2 + 1, {4'd0, ALLRAM_BANKS[v[2:1] * 4 + seg], 1'b1});
                        end
                    end
                    else
                    begin
                        map_rom_pair();
                    end
                end
            end
            ACT_EXT_PORT:
            begin
                if (lock_held())
                begin
                    dropped = 1'b1;
                end
                else
                begin
                    ext_bank = v[4:0] & EXT_MASK;
                    rebuild_mapping();
                end
            end
            ACT_EFF7_PORT:
            begin
                ram_at_zero = {v[3], v[2]};
                rebuild_mapping();
            end
            ACT_MODE_REG:
            begin
                map_mode = v[1:0];
                rebuild_mapping();
            end
            ACT_SET_RAM: map_ram(s, v);
            ACT_MAP_ROM:
            begin
                pages[s]     = v;
                rom_flags[s] = 1'b1;
                views[s]     = VIEW_ROM;
            end
            ACT_SOFT_RESET:
            begin
                load_home_table();
                rebuild_mapping();
            end
            ACT_HARD_RESET:
            begin
                load_home_table();
                bank_port   = '0;
                plus3_port  = '0;
                ext_bank    = '0;
                ram_at_zero = '0;
                lock_bit    = 1'b0;
            end
            default: ;
        endcase
        r.slot_page     = pages[s];
        r.slot_is_rom   = rom_flags[s];
        r.register_view = views[s];
        r.lock_active   = lock_held();
        r.write_ignored = dropped;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("bmsm_checker: %s got 0x%0h expected 0x%0h at %0t", what, got, want, $time);
        mismatch_cnt++;
    endtask

    task automatic check_field(input string what, input int got, input int want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            load_home_table();
            bank_port    = '0;
            plus3_port   = '0;
            ext_bank     = '0;
            ram_at_zero  = '0;
            map_mode     = '0;
            lock_bit     = 1'b0;
            mismatch_cnt = 0;
            pending_results.delete();
        end
        else
        begin
            // Retire the oldest expectation against the result leaving the block.
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch("unexpected result", m_tdata, 0);
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("slot_page",     m_tdata[7:0],  want.slot_page);
                    check_field("slot_is_rom",   m_tdata[8],    want.slot_is_rom);
                    check_field("register_view", m_tdata[16:9], want.register_view);
                    check_field("lock_active",   m_tdata[17],   want.lock_active);
                    check_field("write_ignored", m_tdata[18],   want.write_ignored);
                end
            end
            if (s_tvalid && s_tready)
                pending_results.push_back(apply_paging(s_tdata[3:0], s_tdata[6:4],
                                                       s_tdata[14:7]));
        end
        errors      <= mismatch_cnt;
        outstanding <= pending_results.size();
    end

endmodule

@@ sim/tb_top.sv @@
// Testbench top for the slot mapper: clock, reset, item stimulus and final verdict.
module tb_top;
    import bmsm_pkg::*;

    localparam int RANDOM_ITEMS = 1900;
    localparam int IDLE_PCT     = 19;
    // Random items sent with both sides running flat out.
    localparam int CALM_FIRST   = 700;
    localparam int CALM_LAST    = 1000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;      // action[3:0], slot[6:4], value[14:7], zero[15]
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;      // slot_page[7:0], slot_is_rom[8], register_view[16:9],
                               // lock_active[17], write_ignored[18], zero[23:19]
    int          errors;
    int          outstanding;
    logic        calm;

    banked_memory_slot_mapper u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    bmsm_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Hard stop in case the block hangs or results go missing.
    initial
    begin
        #1_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    // Result side: stall at random, except during the calm stretch.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic logic [15:0] pack_item(input logic [3:0] code, input logic [2:0] s,
                                             input logic [7:0] v);
        return {1'b0, v, s, code};
    endfunction

    // Present one item, after idle cycles drawn one at a time, and hold it until taken.
    task automatic send_item(input logic [15:0] item);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= item;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Draw one random item; port writes and resets are weighted so the lock
    // gets set now and then but does not freeze the ports for long.
    function automatic logic [15:0] random_item();
        int         pick;
        logic [3:0] code;
        logic [7:0] v;
        pick = $urandom_range(99);
        v    = 8'($urandom_range(255));
        if (pick < 18)
        begin
            code = ACT_BANK_PORT;
            // Drop the lock bit in most bank writes.
            if ($urandom_range(3) != 0)
                v[5] = 1'b0;
        end
        else if (pick < 30) code = ACT_PLUS3_PORT;
        else if (pick < 40) code = ACT_EXT_PORT;
        else if (pick < 50) code = ACT_EFF7_PORT;
        else if (pick < 58) code = ACT_MODE_REG;
        else if (pick < 70) code = ACT_SET_RAM;
        else if (pick < 78) code = ACT_MAP_ROM;
        else if (pick < 88) code = ACT_READ;
        else if (pick < 92) code = ACT_SOFT_RESET;
        else if (pick < 97) code = ACT_HARD_RESET;
        else code = ACT_HARD_RESET + 4'd1 + 4'($urandom_range(5));
        return pack_item(code, 3'($urandom_range(7)), v);
    endfunction

    initial
    begin
        logic [15:0] directed [$];
        logic [15:0] item;
        int          counted;

        rst_n    = 1'b0;
        calm     = 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: reset view, direct slot writes at the value extremes,
        // every port, the lock and its cancellation in 1024 mode, both resets
        // and the unused action codes.
        directed = '{
            pack_item(ACT_READ,       3'd0, 8'h00),
            pack_item(ACT_SET_RAM,    3'd2, 8'hFF),
            pack_item(ACT_MAP_ROM,    3'd3, 8'h00),
            pack_item(ACT_MAP_ROM,    3'd7, 8'hFF),
            pack_item(ACT_EXT_PORT,   3'd6, 8'hFF),
            pack_item(ACT_EFF7_PORT,  3'd0, 8'h0C),
            pack_item(ACT_PLUS3_PORT, 3'd1, 8'h07),
            pack_item(ACT_PLUS3_PORT, 3'd0, 8'h04),
            pack_item(ACT_BANK_PORT,  3'd6, 8'h37),
            pack_item(ACT_BANK_PORT,  3'd6, 8'h00),
            pack_item(ACT_PLUS3_PORT, 3'd0, 8'h01),
            pack_item(ACT_EXT_PORT,   3'd7, 8'h00),
            pack_item(ACT_MODE_REG,   3'd6, 8'hFF),
            pack_item(ACT_EFF7_PORT,  3'd6, 8'h00),
            pack_item(ACT_BANK_PORT,  3'd7, 8'hFF),
            pack_item(ACT_EFF7_PORT,  3'd0, 8'h04),
            pack_item(ACT_BANK_PORT,  3'd6, 8'h00),
            pack_item(ACT_SOFT_RESET, 3'd7, 8'h00),
            pack_item(ACT_MODE_REG,   3'd6, 8'h02),
            pack_item(ACT_HARD_RESET, 3'd0, 8'hFF),
            pack_item(ACT_HARD_RESET + 4'd1, 3'd5, 8'h55),
            pack_item(4'hF,           3'd2, 8'hAA),
            pack_item(ACT_READ,       3'd4, 8'h00),
            pack_item(ACT_SOFT_RESET, 3'd1, 8'h00)
        };
        foreach (directed[i])
            send_item(directed[i]);

        // Random part; unused action codes do not advance the count.
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            calm = (counted >= CALM_FIRST && counted < CALM_LAST);
            item = random_item();
            send_item(item);
            if (item[3:0] <= ACT_HARD_RESET)
                counted++;
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;

        // Drain: let the last push reach the checker, wait for all results,
        // then keep waiting so that any stray result can still show up.
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (errors == 0 && outstanding == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
